// ===== src/priority_scheduler_rotating_ties_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the priority scheduler
// Concurrent checks clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_SCHEDULER_ROTATING_TIES_UNIT_MACROS_SVH
`define PRIORITY_SCHEDULER_ROTATING_TIES_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define PRS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("scheduler check failed");

// expression must never be true outside reset
`define PRS_ASSERT_NEVER(label, expr) \
  `PRS_ASSERT(label, !(expr))

`else

`define PRS_ASSERT(label, prop)
`define PRS_ASSERT_NEVER(label, expr)

`endif

`endif

// ===== src/prs_pkg.sv =====
// ----------------------------------------------------------------------------
// prs_pkg
// Shared sizes, command codes and beat types of the priority scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package prs_pkg;

  // table geometry
  localparam int NUM_SLOTS = 64;
  localparam int PRIO_BITS = 5;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // command codes
  localparam logic CMD_WRITE    = 1'b0;
  localparam logic CMD_SCHEDULE = 1'b1;

  typedef logic [IDX_W-1:0]     slot_idx_t;
  typedef logic [PRIO_BITS-1:0] prio_t;

  // one table entry as stored in the memory
  typedef struct packed {
    logic  run;
    prio_t prio;
  } entry_t;

  // input beat
  typedef struct packed {
    logic       command;
    logic [5:0] slot_index;
    logic       make_runnable;
    logic [4:0] slot_priority;
  } in_beat_t;

  // output beat
  typedef struct packed {
    logic       granted;
    logic [5:0] grant_index;
    logic [4:0] grant_priority;
  } out_beat_t;

  // result handed from the scan engine to the output register
  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } res_t;

endpackage

`default_nettype wire

// ===== src/priority_scheduler_rotating_ties_unit.sv =====
// Write beat: accepted while idle, the next beat is taken in the following cycle.
// Schedule beat: the scan engine reads one slot per cycle, the read data is registered,
// and the result then passes through the output register before it is valid at the output.
// The next beat is accepted only once the output register has taken the result.
// Reset clears entry valid bits and the scan pointer at once; no clearing pass.
// ----------------------------------------------------------------------------
// priority_scheduler_rotating_ties_unit
// Priority scheduler with round-robin tie break over a table of task slots.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_scheduler_rotating_ties_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire prs_pkg::in_beat_t   in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output prs_pkg::out_beat_t       out_data_o
);
  import prs_pkg::*;

  res_t res;
  logic res_stall;

  // table and scan engine
  prs_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .res_o      (res),
    .res_stall_i(res_stall)
  );

  // output register
  prs_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_i      (res),
    .res_stall_o(res_stall),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// ===== src/prs_core.sv =====
// ----------------------------------------------------------------------------
// prs_core
// Slot table memory and scan engine: writes entries, scans all slots one per
// cycle in rotated order and writes back the winner with its flag cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "priority_scheduler_rotating_ties_unit_macros.svh"

module prs_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire prs_pkg::in_beat_t in_data_i,
  output prs_pkg::res_t         res_o,
  input  wire logic             res_stall_i
);
  import prs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_DONE
  } state_e;

  localparam slot_idx_t LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  function automatic slot_idx_t next_slot(slot_idx_t s);
    return (s == LAST_IDX) ? '0 : s + 1'b1;
  endfunction

  state_e    state_q;
  slot_idx_t addr_q;
  slot_idx_t cnt_q;
  slot_idx_t scan_start_q;
  slot_idx_t best_idx_q;
  prio_t     best_pri_q;
  logic      found_q;
  logic      pipe_vld_q;

  // read side of the table
  entry_t    mem_q [NUM_SLOTS];
  entry_t    rd_data_q;
  slot_idx_t rd_idx_q;
  logic      rd_vld_bit_q;
  logic [NUM_SLOTS-1:0] vld_q;

  logic      in_acc;
  logic      in_range;
  logic      wr_cmd;
  logic      res_take;
  logic      mem_we;
  logic      mem_re;
  slot_idx_t mem_wa;
  entry_t    mem_wd;
  logic      cand_better;

  // handshake and command decode
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign in_range   = (32'(in_data_i.slot_index) < 32'(NUM_SLOTS));
  assign wr_cmd     = in_acc && (in_data_i.command == CMD_WRITE) && in_range;
  assign res_take   = (state_q == ST_DONE) && !res_stall_i;

  // memory port control: writes from commands or winner write-back, reads in scan
  assign mem_we = wr_cmd || (res_take && found_q);
  assign mem_re = (state_q == ST_SCAN);
  assign mem_wa = wr_cmd ? IDX_W'(in_data_i.slot_index) : best_idx_q;
  always_comb begin
    if (wr_cmd) begin
      mem_wd = '{run: in_data_i.make_runnable, prio: PRIO_BITS'(in_data_i.slot_priority)};
    end else begin
      mem_wd = '{run: 1'b0, prio: best_pri_q};
    end
  end

  // candidate from the previous read beats the best so far (strictly smaller)
  assign cand_better = pipe_vld_q && rd_vld_bit_q && rd_data_q.run &&
                       (!found_q || (rd_data_q.prio < best_pri_q));

  // slot table, one write and one read port, registered read data
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q    <= mem_q[addr_q];
      rd_idx_q     <= addr_q;
      rd_vld_bit_q <= vld_q[addr_q];
    end
  end

  // entry valid bits: an unwritten entry reads as not runnable
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_cmd) begin
      vld_q[mem_wa] <= 1'b1;
    end
  end

  // scan sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      addr_q       <= '0;
      cnt_q        <= '0;
      scan_start_q <= '0;
      best_idx_q   <= '0;
      best_pri_q   <= '0;
      found_q      <= 1'b0;
      pipe_vld_q   <= 1'b0;
    end else begin
      pipe_vld_q <= (state_q == ST_SCAN);
      if (cand_better) begin
        found_q    <= 1'b1;
        best_idx_q <= rd_idx_q;
        best_pri_q <= rd_data_q.prio;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && (in_data_i.command == CMD_SCHEDULE)) begin
            state_q    <= ST_SCAN;
            addr_q     <= scan_start_q;
            cnt_q      <= '0;
            found_q    <= 1'b0;
            best_idx_q <= '0;
            best_pri_q <= '0;
          end
        end
        ST_SCAN: begin
          addr_q <= next_slot(addr_q);
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == LAST_IDX) begin
            state_q <= ST_LAST;
          end
        end
        ST_LAST: begin
          // last read is evaluated this cycle
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (res_take) begin
            if (found_q) begin
              scan_start_q <= next_slot(best_idx_q);
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // result beat
  always_comb begin
    res_o.valid               = (state_q == ST_DONE);
    res_o.beat.granted        = found_q;
    res_o.beat.grant_index    = found_q ? 6'(best_idx_q) : 6'd0;
    res_o.beat.grant_priority = found_q ? 5'(best_pri_q) : 5'd0;
  end

  // checks
  `PRS_ASSERT_NEVER(a_mem_port_conflict, mem_we && mem_re)
  `PRS_ASSERT(a_scan_starts_at_pointer, (in_acc && (in_data_i.command == CMD_SCHEDULE)) |=> ((state_q == ST_SCAN) && (cnt_q == '0) && (addr_q == $past(scan_start_q))))
  `PRS_ASSERT(a_winner_was_written, ((state_q == ST_DONE) && found_q) |-> vld_q[best_idx_q])
  `PRS_ASSERT(a_pointer_follows_winner, (res_take && found_q) |=> (scan_start_q == next_slot($past(best_idx_q))))

endmodule

`default_nettype wire

// ===== src/prs_obuf.sv =====
// ----------------------------------------------------------------------------
// prs_obuf
// One-entry output register between the scan engine and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_obuf (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire prs_pkg::res_t      res_i,
  output logic                    res_stall_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output prs_pkg::out_beat_t      out_data_o
);
  import prs_pkg::*;

  logic      full_q;
  out_beat_t data_q;
  logic      load;

  // take a new beat when empty or when the held one leaves this cycle
  assign res_stall_o = full_q && out_stall_i;
  assign load        = res_i.valid && !res_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (load) begin
      full_q <= 1'b1;
    end else if (!out_stall_i) begin
      full_q <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= res_i.beat;
    end
  end

  assign out_valid_o = full_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// ===== test/priority_scheduler_rotating_ties_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_scheduler_rotating_ties_unit_tb
// Drives write and schedule beats into the scheduler and tracks the slot
// table alongside it. Every grant beat is compared field by field with the
// predicted grant, under random idle bursts on both sides and one long
// output hold-off that backs up the input.
// ----------------------------------------------------------------------------

module priority_scheduler_rotating_ties_unit_tb;
  import prs_pkg::*;

  // Tracks the slot table and queues the grants it predicts
  class grant_tracker;
    logic      slot_run  [NUM_SLOTS];
    prio_t     slot_prio [NUM_SLOTS];
    slot_idx_t next_start;
    out_beat_t pending_grants[$];

    function new();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_run[i]  = 1'b0;
        slot_prio[i] = '0;
      end
      next_start = '0;
    endfunction

    // note an accepted request beat and predict its grant, if any
    function void note_request(in_beat_t b);
      out_beat_t g;
      int        s;
      int        best_slot;
      prio_t     best_prio;
      bit        found;
      if (b.command == CMD_WRITE) begin
        if (int'(b.slot_index) < NUM_SLOTS) begin
          slot_run[b.slot_index]  = b.make_runnable;
          slot_prio[b.slot_index] = prio_t'(b.slot_priority);
        end
        return;
      end
      found     = 1'b0;
      best_slot = 0;
      best_prio = '0;
      // rotated scan; strict less-than keeps the first of equal priorities
      for (int i = 0; i < NUM_SLOTS; i++) begin
        s = (int'(next_start) + i) % NUM_SLOTS;
        if (slot_run[s] && (!found || slot_prio[s] < best_prio)) begin
          found     = 1'b1;
          best_slot = s;
          best_prio = slot_prio[s];
        end
      end
      g = '0;
      if (found) begin
        slot_run[best_slot] = 1'b0;
        next_start          = slot_idx_t'((best_slot + 1) % NUM_SLOTS);
        g.granted           = 1'b1;
        g.grant_index       = 6'(best_slot);
        g.grant_priority    = 5'(best_prio);
      end
      pending_grants.push_back(g);
    endfunction

    // compare a grant beat with the oldest prediction; empty string on match
    function string check_grant(out_beat_t got);
      out_beat_t want;
      string     notes;
      if (pending_grants.size() == 0)
        return $sformatf(" grant beat %0h with none expected", got);
      want  = pending_grants.pop_front();
      notes = "";
      if (got.granted !== want.granted)
        notes = {notes, $sformatf(" granted %0b exp %0b", got.granted, want.granted)};
      if (got.grant_index !== want.grant_index)
        notes = {notes, $sformatf(" grant_index %0d exp %0d",
                                  got.grant_index, want.grant_index)};
      if (got.grant_priority !== want.grant_priority)
        notes = {notes, $sformatf(" grant_priority %0d exp %0d",
                                  got.grant_priority, want.grant_priority)};
      return notes;
    endfunction

    function int pending();
      return pending_grants.size();
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  grant_tracker grants = new();
  int           mismatches  = 0;
  bit           idling_on   = 1'b1;
  int           hold_cycles = 0;
  int           burst_left  = 0;

  priority_scheduler_rotating_ties_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string notes);
    $display("%0t grant mismatch:%s", $time, notes);
    mismatches++;
  endtask

  // Grant side: check accepted beats, then pick the next stall value
  always @(posedge clk) begin
    string notes;
    if (rst_n && out_valid && !out_stall) begin
      notes = grants.check_grant(out_data);
      if (notes != "") report_mismatch(notes);
    end
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else if (burst_left > 0) begin
      out_stall <= 1'b1;
      burst_left--;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      burst_left = $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one request beat, with an optional idle burst in front
  task automatic send_beat(input in_beat_t b);
    int gap;
    if (idling_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    grants.note_request(b);
  endtask

  function automatic in_beat_t write_beat(int idx, bit run, int prio);
    in_beat_t b;
    b.command       = CMD_WRITE;
    b.slot_index    = 6'(idx);
    b.make_runnable = run;
    b.slot_priority = 5'(prio);
    return b;
  endfunction

  function automatic in_beat_t schedule_beat();
    in_beat_t b;
    b            = '0;
    b.command    = CMD_SCHEDULE;
    return b;
  endfunction

  // random beat; priorities lean toward a few low values to force ties
  function automatic in_beat_t random_request();
    in_beat_t b;
    b.command       = ($urandom_range(0, 99) < 40) ? CMD_SCHEDULE : CMD_WRITE;
    b.slot_index    = 6'($urandom_range(0, 63));
    b.make_runnable = ($urandom_range(0, 4) != 0);
    b.slot_priority = ($urandom_range(0, 2) == 0) ? 5'($urandom_range(0, 31))
                                                  : 5'($urandom_range(0, 3));
    return b;
  endfunction

  // Run limit
  initial begin
    #8_000_000;
    $display("priority_scheduler_rotating_ties_unit test failed");
    $finish;
  end

  // Main sequence
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table gives no grant
    send_beat(schedule_beat());
    // extremes of index and priority, tie at zero broken by scan order
    send_beat(write_beat(0, 1'b1, 31));
    send_beat(write_beat(63, 1'b1, 0));
    send_beat(write_beat(5, 1'b1, 0));
    send_beat(schedule_beat());
    send_beat(schedule_beat());
    send_beat(schedule_beat());
    send_beat(schedule_beat());
    // slot written but not runnable
    send_beat(write_beat(42, 1'b0, 7));
    send_beat(schedule_beat());
    // equal priorities served round robin
    send_beat(write_beat(10, 1'b1, 3));
    send_beat(write_beat(20, 1'b1, 3));
    send_beat(write_beat(30, 1'b1, 3));
    send_beat(schedule_beat());
    send_beat(write_beat(10, 1'b1, 3));
    send_beat(schedule_beat());
    send_beat(schedule_beat());
    send_beat(schedule_beat());
    // overwrite a runnable slot to not runnable
    send_beat(write_beat(63, 1'b1, 31));
    send_beat(write_beat(63, 1'b0, 31));
    send_beat(schedule_beat());

    // random traffic with idling on both sides
    repeat (300) send_beat(random_request());

    // long output hold-off while requests keep coming
    hold_cycles = 600;
    repeat (200) send_beat(random_request());

    // closing stretch without idling
    idling_on = 1'b0;
    repeat (250) send_beat(random_request());
    in_valid <= 1'b0;

    while (grants.pending() != 0) @(posedge clk);
    repeat (NUM_SLOTS + 8) @(posedge clk);

    if (mismatches == 0 && grants.pending() == 0) begin
      $display("priority_scheduler_rotating_ties_unit test passed");
    end else begin
      $display("priority_scheduler_rotating_ties_unit test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/prs_pkg.sv
src/prs_core.sv
src/prs_obuf.sv
src/priority_scheduler_rotating_ties_unit.sv
test/priority_scheduler_rotating_ties_unit_tb.sv
